>>> design/cdm_pkg.sv
`default_nettype none
package cdm_pkg;

   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_SEND = 2'd1;
   localparam logic [1:0] OP_RX   = 2'd2;

   localparam logic [2:0] K_RTS   = 3'd0;
   localparam logic [2:0] K_CTS   = 3'd1;
   localparam logic [2:0] K_DATA  = 3'd2;
   localparam logic [2:0] K_ACK   = 3'd3;
   localparam logic [2:0] K_BCAST = 3'd4;

   localparam logic [2:0] A_NONE     = 3'd0;
   localparam logic [2:0] A_TX       = 3'd1;
   localparam logic [2:0] A_DELIVER  = 3'd2;
   localparam logic [2:0] A_RADIO_RX = 3'd3;
   localparam logic [2:0] A_SENT     = 3'd4;
   localparam logic [2:0] A_DROP     = 3'd5;
   localparam logic [2:0] A_FULL     = 3'd6;

   localparam logic [3:0] ST_IDLE        = 4'd0;
   localparam logic [3:0] ST_BACKOFF     = 4'd1;
   localparam logic [3:0] ST_RTS         = 4'd2;
   localparam logic [3:0] ST_TIMEOUT     = 4'd3;
   localparam logic [3:0] ST_CTS         = 4'd4;
   localparam logic [3:0] ST_CTS_TIMEOUT = 4'd5;
   localparam logic [3:0] ST_DATA        = 4'd6;
   localparam logic [3:0] ST_BROADCAST   = 4'd7;
   localparam logic [3:0] ST_ACK         = 4'd8;
   localparam logic [3:0] ST_DONE        = 4'd9;
   localparam logic [3:0] ST_BROAD_DONE  = 4'd10;

   localparam logic [2:0] CSR_OWN_ADDRESS   = 3'd0;
   localparam logic [2:0] CSR_RTS_THRESHOLD = 3'd1;
   localparam logic [2:0] CSR_MAX_RETRIES   = 3'd2;
   localparam logic [2:0] CSR_BIT_TIME      = 3'd3;
   localparam logic [2:0] CSR_PHY_HEADER    = 3'd4;
   localparam logic [2:0] CSR_ENERGY_THR    = 3'd5;
   localparam logic [2:0] CSR_CS_ENABLE     = 3'd6;
   localparam logic [2:0] CSR_NOISE_ENABLE  = 3'd7;

   localparam logic [31:0] DIFS_NS = 32'd50000;
   localparam logic [31:0] SIFS_NS = 32'd10000;
   localparam logic [15:0] SLOT_NS = 16'd20000;
   localparam logic [31:0] PROP_NS = 32'd3000;
   localparam logic [4:0]  BE_MIN  = 5'd5;
   localparam logic [4:0]  BE_MAX  = 5'd10;
   localparam logic [11:0] CTL_BYTES     = 12'd10;
   localparam logic [11:0] RTS_BYTES     = 12'd16;
   localparam logic [12:0] MAC_HDR_BYTES = 13'd32;
   localparam logic [2:0]  MAX_RES = 3'd4;

   typedef struct packed {
      logic [2:0]  action;
      logic [2:0]  frame_kind;
      logic [15:0] peer_address;
      logic [31:0] frame_duration_ns;
      logic [11:0] frame_bytes;
   } res_type;

   function automatic logic [47:0] sat48(input logic [48:0] x);
      sat48 = x[48] ? 48'hFFFF_FFFF_FFFF : x[47:0];
   endfunction

   function automatic logic [31:0] sat32(input logic [33:0] x);
      sat32 = (x[33:32] != 2'b00) ? 32'hFFFF_FFFF : x[31:0];
   endfunction

   function automatic res_type make_res(input logic [2:0] act, input logic [2:0] kind,
                                        input logic [15:0] pa, input logic [31:0] dur,
                                        input logic [11:0] bytes);
      res_type r;
      r.action = act;
      r.frame_kind = kind;
      r.peer_address = pa;
      r.frame_duration_ns = dur;
      r.frame_bytes = bytes;
      make_res = r;
   endfunction

endpackage
`default_nettype wire

>>> design/cdm_req_if.sv
`default_nettype none
interface cdm_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         op;
   logic [47:0]        now_time;
   logic signed [7:0]  carrier_level_dbm;
   logic signed [7:0]  noise_level_dbm;
   logic [15:0]        random_fraction;
   logic [15:0]        request_dest;
   logic [11:0]        request_payload_bytes;
   logic [2:0]         rx_frame_kind;
   logic [15:0]        rx_source;
   logic [15:0]        rx_dest;
   logic [31:0]        rx_duration_ns;
   logic [11:0]        rx_bytes;

   modport source (output valid, op, now_time, carrier_level_dbm, noise_level_dbm,
                   random_fraction, request_dest, request_payload_bytes, rx_frame_kind,
                   rx_source, rx_dest, rx_duration_ns, rx_bytes, input ready);
   modport sink (input valid, op, now_time, carrier_level_dbm, noise_level_dbm,
                 random_fraction, request_dest, request_payload_bytes, rx_frame_kind,
                 rx_source, rx_dest, rx_duration_ns, rx_bytes, output ready);
endinterface
`default_nettype wire

>>> design/cdm_rsp_if.sv
`default_nettype none
interface cdm_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [2:0]  frame_kind;
   logic [15:0] peer_address;
   logic [31:0] frame_duration_ns;
   logic [11:0] frame_bytes;
   logic        last;

   modport source (output valid, action, frame_kind, peer_address, frame_duration_ns,
                   frame_bytes, last, input ready);
   modport sink (input valid, action, frame_kind, peer_address, frame_duration_ns,
                 frame_bytes, last, output ready);
endinterface
`default_nettype wire

>>> design/cdm_ram.sv
`default_nettype none
module cdm_ram #(
   parameter int WIDTH = 28,
   parameter int DEPTH = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                     wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

>>> design/csma_ca_dcf_mac_controller.sv
`default_nettype none
// Each beat in is registered, decoded and run through the state machine steps; a frame
// transmission adds the airtime states, using the shared multiplier. Result beats go out one
// per cycle while the receiver is ready. One item is handled at a time.
// The airtime and backoff products all pass through a single registered multiplier.
// Reset is synchronous and clears the control state; the request queue memory is not cleared.
module csma_ca_dcf_mac_controller #(
   parameter int QUEUE_DEPTH = 8,
   parameter int ADDR_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   cdm_req_if.sink          req_bus,
   cdm_rsp_if.source        rsp_bus,
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wr_data
);
   import cdm_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int MB = (ADDR_BITS < 16) ? ADDR_BITS : 16;
   localparam logic [16:0] MASK17 = (17'd1 << MB) - 17'd1;
   localparam logic [15:0] ADDR_MASK = MASK17[15:0];

   localparam logic [3:0] Q_IDLE   = 4'd0;
   localparam logic [3:0] Q_DECODE = 4'd1;
   localparam logic [3:0] Q_MACH   = 4'd2;
   localparam logic [3:0] Q_FIFO   = 4'd3;
   localparam logic [3:0] Q_BO     = 4'd4;
   localparam logic [3:0] Q_AIR0   = 4'd5;
   localparam logic [3:0] Q_AIR1   = 4'd6;
   localparam logic [3:0] Q_AIR2   = 4'd7;
   localparam logic [3:0] Q_WAIT   = 4'd8;
   localparam logic [3:0] Q_SEND   = 4'd9;
   localparam logic [3:0] Q_OUT    = 4'd10;

   logic [15:0] own_ff, own_in;
   logic [11:0] rts_thr_ff, rts_thr_in;
   logic [7:0]  max_retry_ff, max_retry_in;
   logic [15:0] bit_time_ff, bit_time_in;
   logic [7:0]  phy_ff, phy_in;
   logic signed [7:0] thr_ff, thr_in;
   logic        cs_en_ff, cs_en_in;
   logic        noise_en_ff, noise_en_in;

   logic [3:0]  seq_ff, seq_in;
   logic [3:0]  mac_state_ff, mac_state_in;
   logic [3:0]  pending_ff, pending_in;
   logic [15:0] peer_ff, peer_in;
   logic [11:0] announced_ff, announced_in;
   logic [31:0] backoff_ff, backoff_in;
   logic        susp_ff, susp_in;
   logic [7:0]  retry_ff, retry_in;
   logic [3:0]  be_ff, be_in;
   logic [47:0] nav_ff, nav_in;
   logic [47:0] main_dl_ff, main_dl_in;
   logic        main_arm_ff, main_arm_in;
   logic [47:0] radio_dl_ff, radio_dl_in;
   logic        radio_arm_ff, radio_arm_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic        cur_valid_ff, cur_valid_in;
   logic [15:0] cur_dest_ff, cur_dest_in;
   logic [11:0] cur_bytes_ff, cur_bytes_in;
   logic [3:0]  guard_ff, guard_in;
   logic [2:0]  res_n_ff, res_n_in;
   logic [2:0]  res_rd_ff, res_rd_in;

   logic [1:0]  it_op_ff;
   logic [47:0] it_now_ff;
   logic signed [7:0] it_carrier_ff, it_noise_ff;
   logic [15:0] it_rnd_ff, it_rq_dest_ff, it_src_ff, it_dst_ff;
   logic [11:0] it_rq_pay_ff, it_rbytes_ff;
   logic [2:0]  it_kind_ff;
   logic [31:0] it_dur_ff;

   logic [31:0] air_ctl_ff, air_ctl_in;
   logic [31:0] air_x_ff, air_x_in;
   logic [31:0] air_rts_ff, air_rts_in;
   logic [33:0] nav_sum_ff, nav_sum_in;
   logic [33:0] wait_sum_ff, wait_sum_in;
   logic [41:0] p_ff, p_in;
   res_type     res_ff [4];
   res_type     res_in [4];

   logic        accept;
   logic        busy_c, for_us_c, cur_bcast_c, rq_bcast_c;
   logic [12:0] total_c;
   logic [11:0] total_sat_c;
   logic [CNT_W:0] tail_sum_c;
   logic [PTR_W-1:0] tail_c, head_next_c;
   logic [4:0]  be_inc_c;
   logic [7:0]  retry_inc_c;
   logic [11:0] x_bytes_c;
   logic [25:0] mul_a_c;
   logic [15:0] mul_b_c;
   logic [25:0] bo_fac_c;
   logic [31:0] pkt_c;
   logic        ram_we;
   logic [27:0] ram_rd_data;
   logic        push_a_v, push_b_v;
   res_type     push_a, push_b;
   logic [2:0]  n_a;
   res_type     out_c;

   assign accept = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (seq_ff == Q_IDLE);

   assign busy_c = (cs_en_ff && (it_carrier_ff >= thr_ff)) ||
                   (noise_en_ff && (it_noise_ff >= thr_ff));
   assign for_us_c = (it_dst_ff == (own_ff & ADDR_MASK));
   assign cur_bcast_c = (cur_dest_ff == ADDR_MASK);
   assign rq_bcast_c = (it_rq_dest_ff == ADDR_MASK);
   assign total_c = {1'b0, it_rq_pay_ff} + MAC_HDR_BYTES;
   assign total_sat_c = total_c[12] ? 12'hFFF : total_c[11:0];
   assign tail_sum_c = (CNT_W+1)'(head_ff) + (CNT_W+1)'(count_ff);
   assign tail_c = (tail_sum_c >= (CNT_W+1)'(QUEUE_DEPTH)) ?
                   PTR_W'(tail_sum_c - (CNT_W+1)'(QUEUE_DEPTH)) : PTR_W'(tail_sum_c);
   assign head_next_c = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign be_inc_c = ({1'b0, be_ff} + 5'd1 > BE_MAX) ? BE_MAX : {1'b0, be_ff} + 5'd1;
   assign retry_inc_c = retry_ff + 8'd1;
   assign x_bytes_c = (mac_state_ff == ST_CTS) ? announced_ff : cur_bytes_ff;
   assign bo_fac_c = ({10'b0, it_rnd_ff} << be_inc_c) - {10'b0, it_rnd_ff};
   assign p_in = mul_a_c * mul_b_c;

   always_comb begin
      own_in = own_ff; rts_thr_in = rts_thr_ff; max_retry_in = max_retry_ff;
      bit_time_in = bit_time_ff; phy_in = phy_ff; thr_in = thr_ff;
      cs_en_in = cs_en_ff; noise_en_in = noise_en_ff;
      seq_in = seq_ff; mac_state_in = mac_state_ff; pending_in = pending_ff;
      peer_in = peer_ff; announced_in = announced_ff; backoff_in = backoff_ff;
      susp_in = susp_ff; retry_in = retry_ff; be_in = be_ff; nav_in = nav_ff;
      main_dl_in = main_dl_ff; main_arm_in = main_arm_ff;
      radio_dl_in = radio_dl_ff; radio_arm_in = radio_arm_ff;
      count_in = count_ff; head_in = head_ff; cur_valid_in = cur_valid_ff;
      cur_dest_in = cur_dest_ff; cur_bytes_in = cur_bytes_ff; guard_in = guard_ff;
      res_n_in = res_n_ff; res_rd_in = res_rd_ff;
      air_ctl_in = air_ctl_ff; air_x_in = air_x_ff; air_rts_in = air_rts_ff;
      nav_sum_in = nav_sum_ff; wait_sum_in = wait_sum_ff;
      res_in = res_ff;
      push_a_v = 1'b0; push_b_v = 1'b0;
      push_a = make_res(A_RADIO_RX, 3'd0, 16'd0, 32'd0, 12'd0);
      push_b = push_a;
      ram_we = 1'b0;
      pkt_c = air_x_ff;
      mul_a_c = 26'({1'b0, CTL_BYTES} + {5'b0, phy_ff});
      mul_b_c = bit_time_ff;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_OWN_ADDRESS:   own_in = csr_wr_data;
            CSR_RTS_THRESHOLD: rts_thr_in = csr_wr_data[11:0];
            CSR_MAX_RETRIES:   max_retry_in = csr_wr_data[7:0];
            CSR_BIT_TIME:      bit_time_in = csr_wr_data;
            CSR_PHY_HEADER:    phy_in = csr_wr_data[7:0];
            CSR_ENERGY_THR:    thr_in = csr_wr_data[7:0];
            CSR_CS_ENABLE:     cs_en_in = csr_wr_data[0];
            CSR_NOISE_ENABLE:  noise_en_in = csr_wr_data[0];
            default: ;
         endcase
      end

      case (seq_ff)
         Q_IDLE: begin
            if (accept) begin
               res_n_in = 3'd0;
               res_rd_in = 3'd0;
               guard_in = 4'd0;
               seq_in = Q_DECODE;
            end
         end
         Q_DECODE: begin
            seq_in = Q_OUT;
            case (it_op_ff)
               OP_TICK: begin
                  if (radio_arm_ff && (it_now_ff >= radio_dl_ff)) begin
                     radio_arm_in = 1'b0;
                     push_a_v = 1'b1;
                  end
                  if (main_arm_ff && (it_now_ff >= main_dl_ff)) begin
                     seq_in = Q_MACH;
                  end
               end
               OP_SEND: begin
                  if (count_ff >= CNT_W'(QUEUE_DEPTH)) begin
                     push_a_v = 1'b1;
                     push_a = make_res(A_FULL, rq_bcast_c ? K_BCAST : K_DATA,
                                       it_rq_dest_ff, 32'd0, total_sat_c);
                  end else begin
                     ram_we = 1'b1;
                     count_in = count_ff + 1'b1;
                     if (mac_state_ff == ST_IDLE) begin
                        seq_in = Q_MACH;
                     end
                  end
               end
               OP_RX: begin
                  push_a_v = 1'b1;
                  case (it_kind_ff)
                     K_RTS, K_CTS, K_DATA: begin
                        if (!for_us_c) begin
                           if (nav_ff < sat48({1'b0, it_now_ff} + 49'(it_dur_ff))) begin
                              nav_in = sat48({1'b0, it_now_ff} + 49'(it_dur_ff));
                           end
                        end else if (it_kind_ff == K_RTS) begin
                           if (mac_state_ff == ST_IDLE || mac_state_ff == ST_BACKOFF) begin
                              peer_in = it_src_ff;
                              announced_in = it_rbytes_ff;
                              pending_in = (mac_state_ff == ST_BACKOFF) ? ST_BACKOFF : ST_IDLE;
                              mac_state_in = ST_CTS;
                              main_dl_in = sat48({1'b0, it_now_ff} + 49'(SIFS_NS));
                              main_arm_in = 1'b1;
                           end
                        end else if (it_kind_ff == K_CTS) begin
                           if (mac_state_ff == ST_TIMEOUT && peer_ff == it_src_ff) begin
                              mac_state_in = ST_DATA;
                              main_dl_in = sat48({1'b0, it_now_ff} + 49'(SIFS_NS));
                              main_arm_in = 1'b1;
                           end
                        end else begin
                           if ((mac_state_ff == ST_IDLE || mac_state_ff == ST_BACKOFF ||
                                mac_state_ff == ST_CTS_TIMEOUT) &&
                               !(mac_state_ff == ST_CTS_TIMEOUT && peer_ff != it_src_ff)) begin
                              pending_in = (mac_state_ff == ST_BACKOFF) ? ST_BACKOFF : ST_IDLE;
                              peer_in = it_src_ff;
                              mac_state_in = ST_ACK;
                              main_dl_in = sat48({1'b0, it_now_ff} + 49'(SIFS_NS));
                              main_arm_in = 1'b1;
                              push_b_v = 1'b1;
                              push_b = make_res(A_DELIVER, K_DATA, it_src_ff, 32'd0,
                                                it_rbytes_ff);
                           end
                        end
                     end
                     K_BCAST: begin
                        if (it_dst_ff == ADDR_MASK) begin
                           push_b_v = 1'b1;
                           push_b = make_res(A_DELIVER, K_BCAST, it_src_ff, 32'd0,
                                             it_rbytes_ff);
                        end
                     end
                     K_ACK: begin
                        if (for_us_c && mac_state_ff == ST_TIMEOUT && peer_ff == it_src_ff) begin
                           push_b_v = 1'b1;
                           push_b = make_res(A_SENT, cur_bcast_c ? K_BCAST : K_DATA,
                                             cur_dest_ff, 32'd0, cur_bytes_ff);
                           cur_valid_in = 1'b0;
                           mac_state_in = ST_IDLE;
                           seq_in = Q_MACH;
                        end
                     end
                     default: ;
                  endcase
               end
               default: ;
            endcase
         end
         Q_MACH: begin
            if (guard_ff == 4'd12) begin
               seq_in = Q_OUT;
            end else begin
               guard_in = guard_ff + 4'd1;
               main_arm_in = 1'b0;
               case (mac_state_ff)
                  ST_IDLE: begin
                     if (!cur_valid_ff) begin
                        seq_in = (count_ff == '0) ? Q_OUT : Q_FIFO;
                     end else begin
                        mac_state_in = ST_BACKOFF;
                        pending_in = ST_BACKOFF;
                        be_in = 4'(BE_MIN - 5'd1);
                        retry_in = 8'd0;
                        backoff_in = DIFS_NS;
                        susp_in = 1'b0;
                     end
                  end
                  ST_BACKOFF: begin
                     if (backoff_ff != 32'd0 && backoff_ff < 32'(SLOT_NS)) begin
                        backoff_in = 32'd0;
                     end else if (backoff_ff != 32'd0) begin
                        if ((it_now_ff < nav_ff) || busy_c) begin
                           if (!susp_ff) begin
                              susp_in = 1'b1;
                              backoff_in = sat32({2'b0, backoff_ff} + 34'(DIFS_NS));
                           end
                        end else begin
                           susp_in = 1'b0;
                           backoff_in = backoff_ff - 32'(SLOT_NS);
                        end
                        main_dl_in = sat48({1'b0, it_now_ff} + 49'(SLOT_NS));
                        main_arm_in = 1'b1;
                        seq_in = Q_OUT;
                     end else begin
                        if (cur_bcast_c) begin
                           mac_state_in = ST_BROADCAST;
                        end else if (cur_bytes_ff < rts_thr_ff) begin
                           mac_state_in = ST_DATA;
                        end else begin
                           mac_state_in = ST_RTS;
                        end
                        pending_in = ST_IDLE;
                        peer_in = cur_dest_ff;
                     end
                  end
                  ST_RTS, ST_CTS, ST_DATA, ST_BROADCAST, ST_ACK: begin
                     seq_in = Q_AIR0;
                  end
                  ST_TIMEOUT: begin
                     retry_in = retry_inc_c;
                     if (retry_inc_c >= max_retry_ff) begin
                        push_a_v = 1'b1;
                        push_a = make_res(A_DROP, cur_bcast_c ? K_BCAST : K_DATA,
                                          cur_dest_ff, 32'd0, cur_bytes_ff);
                        cur_valid_in = 1'b0;
                        mac_state_in = ST_IDLE;
                     end else begin
                        be_in = be_inc_c[3:0];
                        mul_a_c = bo_fac_c;
                        mul_b_c = SLOT_NS;
                        seq_in = Q_BO;
                     end
                  end
                  ST_CTS_TIMEOUT, ST_DONE: begin
                     mac_state_in = pending_ff;
                     if (pending_ff != ST_IDLE) begin
                        peer_in = cur_dest_ff;
                     end
                  end
                  ST_BROAD_DONE: begin
                     push_a_v = 1'b1;
                     push_a = make_res(A_SENT, K_BCAST, cur_dest_ff, 32'd0, cur_bytes_ff);
                     cur_valid_in = 1'b0;
                     mac_state_in = ST_IDLE;
                  end
                  default: seq_in = Q_OUT;
               endcase
            end
         end
         Q_FIFO: begin
            cur_dest_in = ram_rd_data[27:12];
            cur_bytes_in = ram_rd_data[11:0];
            cur_valid_in = 1'b1;
            head_in = head_next_c;
            count_in = count_ff - 1'b1;
            mac_state_in = ST_BACKOFF;
            pending_in = ST_BACKOFF;
            be_in = 4'(BE_MIN - 5'd1);
            retry_in = 8'd0;
            backoff_in = DIFS_NS;
            susp_in = 1'b0;
            seq_in = Q_MACH;
         end
         Q_BO: begin
            backoff_in = 32'(p_ff[41:16]) + DIFS_NS;
            susp_in = 1'b0;
            mac_state_in = ST_BACKOFF;
            pending_in = ST_BACKOFF;
            seq_in = Q_MACH;
         end
         Q_AIR0: begin
            air_ctl_in = {p_ff[28:0], 3'b000};
            mul_a_c = 26'({1'b0, x_bytes_c} + {5'b0, phy_ff});
            seq_in = Q_AIR1;
         end
         Q_AIR1: begin
            air_x_in = {p_ff[28:0], 3'b000};
            mul_a_c = 26'({1'b0, RTS_BYTES} + {5'b0, phy_ff});
            seq_in = Q_AIR2;
         end
         Q_AIR2: begin
            air_rts_in = {p_ff[28:0], 3'b000};
            case (mac_state_ff)
               ST_RTS: nav_sum_in = 34'(3 * SIFS_NS) + {1'b0, air_ctl_ff, 1'b0} +
                                    {2'b0, air_x_ff};
               ST_CTS: nav_sum_in = 34'(2 * SIFS_NS) + {2'b0, air_ctl_ff} + {2'b0, air_x_ff};
               ST_DATA: nav_sum_in = 34'(SIFS_NS) + {2'b0, air_ctl_ff};
               default: nav_sum_in = 34'd0;
            endcase
            seq_in = Q_WAIT;
         end
         Q_WAIT: begin
            case (mac_state_ff)
               ST_RTS: wait_sum_in = 34'(SIFS_NS + PROP_NS) + {2'b0, air_ctl_ff} +
                                     {2'b0, air_rts_ff};
               ST_CTS, ST_DATA: wait_sum_in = 34'(SIFS_NS + PROP_NS) + {2'b0, air_ctl_ff} +
                                              {2'b0, air_x_ff};
               ST_BROADCAST: wait_sum_in = 34'(SIFS_NS) + {2'b0, air_x_ff};
               default: wait_sum_in = 34'(SIFS_NS) + {2'b0, air_ctl_ff};
            endcase
            seq_in = Q_SEND;
         end
         Q_SEND: begin
            push_a_v = 1'b1;
            case (mac_state_ff)
               ST_RTS: begin
                  pkt_c = air_rts_ff;
                  push_a = make_res(A_TX, K_RTS, peer_ff, sat32(nav_sum_ff), cur_bytes_ff);
                  mac_state_in = ST_TIMEOUT;
               end
               ST_CTS: begin
                  pkt_c = air_ctl_ff;
                  push_a = make_res(A_TX, K_CTS, peer_ff, sat32(nav_sum_ff), CTL_BYTES);
                  mac_state_in = ST_CTS_TIMEOUT;
               end
               ST_DATA: begin
                  push_a = make_res(A_TX, K_DATA, cur_dest_ff, sat32(nav_sum_ff),
                                    cur_bytes_ff);
                  mac_state_in = ST_TIMEOUT;
               end
               ST_BROADCAST: begin
                  push_a = make_res(A_TX, K_BCAST, cur_dest_ff, 32'd0, cur_bytes_ff);
                  mac_state_in = ST_BROAD_DONE;
               end
               default: begin
                  pkt_c = air_ctl_ff;
                  push_a = make_res(A_TX, K_ACK, peer_ff, 32'd0, CTL_BYTES);
                  mac_state_in = ST_DONE;
               end
            endcase
            radio_dl_in = sat48({1'b0, it_now_ff} + 49'(pkt_c));
            radio_arm_in = 1'b1;
            main_dl_in = sat48({1'b0, it_now_ff} + 49'(wait_sum_ff));
            main_arm_in = 1'b1;
            seq_in = Q_OUT;
         end
         Q_OUT: begin
            if (rsp_bus.valid && rsp_bus.ready) begin
               res_rd_in = res_rd_ff + 3'd1;
            end
            if (res_rd_ff >= res_n_ff) begin
               seq_in = Q_IDLE;
            end
         end
         default: seq_in = Q_IDLE;
      endcase

      n_a = res_n_in;
      if (push_a_v && n_a < MAX_RES) begin
         res_in[n_a[1:0]] = push_a;
         n_a = n_a + 3'd1;
      end
      if (push_b_v && n_a < MAX_RES) begin
         res_in[n_a[1:0]] = push_b;
         n_a = n_a + 3'd1;
      end
      res_n_in = n_a;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ff <= 16'd0;
         rts_thr_ff <= 12'd500;
         max_retry_ff <= 8'd7;
         bit_time_ff <= 16'd1000;
         phy_ff <= 8'd0;
         thr_ff <= -8'sd74;
         cs_en_ff <= 1'b1;
         noise_en_ff <= 1'b1;
         seq_ff <= Q_IDLE;
         mac_state_ff <= ST_IDLE;
         pending_ff <= ST_IDLE;
         peer_ff <= 16'd0;
         announced_ff <= 12'd0;
         backoff_ff <= 32'd0;
         susp_ff <= 1'b0;
         retry_ff <= 8'd0;
         be_ff <= 4'd0;
         nav_ff <= 48'd0;
         main_dl_ff <= 48'd0;
         main_arm_ff <= 1'b0;
         radio_dl_ff <= 48'd0;
         radio_arm_ff <= 1'b0;
         count_ff <= '0;
         head_ff <= '0;
         cur_valid_ff <= 1'b0;
         cur_dest_ff <= 16'd0;
         cur_bytes_ff <= 12'd0;
         guard_ff <= 4'd0;
         res_n_ff <= 3'd0;
         res_rd_ff <= 3'd0;
      end else begin
         own_ff <= own_in;
         rts_thr_ff <= rts_thr_in;
         max_retry_ff <= max_retry_in;
         bit_time_ff <= bit_time_in;
         phy_ff <= phy_in;
         thr_ff <= thr_in;
         cs_en_ff <= cs_en_in;
         noise_en_ff <= noise_en_in;
         seq_ff <= seq_in;
         mac_state_ff <= mac_state_in;
         pending_ff <= pending_in;
         peer_ff <= peer_in;
         announced_ff <= announced_in;
         backoff_ff <= backoff_in;
         susp_ff <= susp_in;
         retry_ff <= retry_in;
         be_ff <= be_in;
         nav_ff <= nav_in;
         main_dl_ff <= main_dl_in;
         main_arm_ff <= main_arm_in;
         radio_dl_ff <= radio_dl_in;
         radio_arm_ff <= radio_arm_in;
         count_ff <= count_in;
         head_ff <= head_in;
         cur_valid_ff <= cur_valid_in;
         cur_dest_ff <= cur_dest_in;
         cur_bytes_ff <= cur_bytes_in;
         guard_ff <= guard_in;
         res_n_ff <= res_n_in;
         res_rd_ff <= res_rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         it_op_ff <= req_bus.op;
         it_now_ff <= req_bus.now_time;
         it_carrier_ff <= req_bus.carrier_level_dbm;
         it_noise_ff <= req_bus.noise_level_dbm;
         it_rnd_ff <= req_bus.random_fraction;
         it_rq_dest_ff <= req_bus.request_dest & ADDR_MASK;
         it_rq_pay_ff <= req_bus.request_payload_bytes;
         it_kind_ff <= req_bus.rx_frame_kind;
         it_src_ff <= req_bus.rx_source & ADDR_MASK;
         it_dst_ff <= req_bus.rx_dest & ADDR_MASK;
         it_dur_ff <= req_bus.rx_duration_ns;
         it_rbytes_ff <= req_bus.rx_bytes;
      end
      air_ctl_ff <= air_ctl_in;
      air_x_ff <= air_x_in;
      air_rts_ff <= air_rts_in;
      nav_sum_ff <= nav_sum_in;
      wait_sum_ff <= wait_sum_in;
      p_ff <= p_in;
      res_ff <= res_in;
   end

   cdm_ram #(
      .WIDTH(28),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (tail_c),
      .wr_data ({it_rq_dest_ff, total_sat_c}),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   assign out_c = res_ff[res_rd_ff[1:0]];
   assign rsp_bus.valid = (seq_ff == Q_OUT) && (res_rd_ff < res_n_ff);
   assign rsp_bus.action = out_c.action;
   assign rsp_bus.frame_kind = out_c.frame_kind;
   assign rsp_bus.peer_address = out_c.peer_address;
   assign rsp_bus.frame_duration_ns = out_c.frame_duration_ns;
   assign rsp_bus.frame_bytes = out_c.frame_bytes;
   assign rsp_bus.last = ((res_rd_ff + 3'd1) == res_n_ff);
endmodule
`default_nettype wire

>>> sim/tb.sv
`default_nettype none
module tb;
   import cdm_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [2:0] K_UNKNOWN = 3'd7;
   localparam logic [15:0] BCAST_ADDR = 16'hFFFF;
   localparam longint unsigned MAX48 = 64'h0000_FFFF_FFFF_FFFF;
   localparam longint unsigned MAX32 = 64'h0000_0000_FFFF_FFFF;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct {
      logic [1:0]        op;
      logic [47:0]       now;
      logic signed [7:0] car;
      logic signed [7:0] noi;
      logic [15:0]       rnd;
      logic [15:0]       rq_dest;
      logic [11:0]       rq_pay;
      logic [2:0]        kind;
      logic [15:0]       src;
      logic [15:0]       dst;
      logic [31:0]       dur;
      logic [11:0]       rb;
   } event_t;

   typedef struct {
      res_type r;
      bit      last;
   } beat_t;

   typedef struct {
      event_t  ev;
      bit      at_deadline;
      bit      typed;
      res_type want;
   } row_t;

   logic clock = 0;
   logic reset = 1;
   logic csr_wr_en = 0;
   logic [2:0] csr_index = '0;
   logic [15:0] csr_wr_data = '0;

   cdm_req_if req ();
   cdm_rsp_if rsp ();

   csma_ca_dcf_mac_controller dut (
      .clock(clock), .reset(reset), .req_bus(req), .rsp_bus(rsp),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   // Configuration and state of the predicted controller.
   logic [15:0] own_addr = 16'd0;
   logic [11:0] rts_thr = 12'd500;
   logic [7:0] retry_max = 8'd7;
   logic [15:0] bit_ns = 16'd1000;
   logic [7:0] phy_hdr = 8'd0;
   logic signed [7:0] energy_thr = -8'sd74;
   bit cs_en = 1, noise_en = 1;

   logic [3:0] st = ST_IDLE, pend_st = ST_IDLE;
   logic [15:0] peer_a = '0;
   logic [11:0] ann_bytes = '0;
   longint unsigned bo_ns = 0;
   bit bo_susp = 0;
   logic [7:0] retries = '0;
   int unsigned bexp = 0;
   longint unsigned nav_t = 0, main_t = 0, radio_t = 0;
   bit main_on = 0, radio_on = 0;
   logic [15:0] q_dest [8];
   logic [11:0] q_bytes [8];
   int q_cnt = 0, q_head = 0;
   bit cur_on = 0;
   logic [15:0] cur_dst = '0;
   logic [11:0] cur_len = '0;

   beat_t step_res[$];
   beat_t pending_beats[$];
   row_t rows[$];
   longint unsigned cur_now = 100;
   int errors = 0;
   int idle_pct = 0, stall_pct = 0;
   int hold_req = 0, hold_seen = 0, hold_left = 0;
   int cycles = 0;

   function automatic longint unsigned clip48(longint unsigned x);
      return x > MAX48 ? MAX48 : x;
   endfunction

   function automatic longint unsigned clip32(longint unsigned x);
      return x > MAX32 ? MAX32 : x;
   endfunction

   function automatic longint unsigned airtime(longint unsigned b);
      return (b + phy_hdr) * 8 * bit_ns;
   endfunction

   function automatic logic [2:0] kind_for(logic [15:0] d);
      return d == BCAST_ADDR ? K_BCAST : K_DATA;
   endfunction

   function automatic void emit(logic [2:0] act, logic [2:0] k, logic [15:0] pa,
                                longint unsigned dur, logic [11:0] b);
      beat_t e;
      if (step_res.size() >= 4) return;
      e.r.action = act;
      e.r.frame_kind = k;
      e.r.peer_address = pa;
      e.r.frame_duration_ns = dur[31:0];
      e.r.frame_bytes = b;
      e.last = 0;
      step_res.push_back(e);
   endfunction

   function automatic void transmit(logic [2:0] k, logic [15:0] d, longint unsigned nav,
                                    logic [11:0] b, longint unsigned pkt,
                                    longint unsigned wait_ns, logic [3:0] nxt,
                                    longint unsigned now);
      emit(A_TX, k, d, clip32(nav), b);
      radio_t = clip48(now + pkt);
      radio_on = 1;
      st = nxt;
      main_t = clip48(now + wait_ns);
      main_on = 1;
   endfunction

   function automatic bit chan_busy(logic signed [7:0] car, logic signed [7:0] noi);
      return (cs_en && car >= energy_thr) || (noise_en && noi >= energy_thr);
   endfunction

   function automatic void run_fsm(longint unsigned now, longint unsigned rnd,
                                   logic signed [7:0] car, logic signed [7:0] noi);
      for (int g = 0; g < 12; g++) begin
         main_on = 0;
         case (st)
            ST_IDLE: begin
               if (!cur_on) begin
                  if (q_cnt == 0) return;
                  cur_dst = q_dest[q_head];
                  cur_len = q_bytes[q_head];
                  cur_on = 1;
                  q_head = (q_head + 1) % 8;
                  q_cnt--;
               end
               st = ST_BACKOFF;
               pend_st = ST_BACKOFF;
               bexp = BE_MIN - 1;
               retries = 0;
               bo_ns = DIFS_NS;
               bo_susp = 0;
            end
            ST_BACKOFF: begin
               if (bo_ns > 0 && bo_ns < SLOT_NS) begin
                  bo_ns = 0;
               end else if (bo_ns > 0) begin
                  if (now < nav_t || chan_busy(car, noi)) begin
                     if (!bo_susp) begin
                        bo_susp = 1;
                        bo_ns = clip32(bo_ns + DIFS_NS);
                     end
                  end else begin
                     bo_susp = 0;
                     bo_ns -= SLOT_NS;
                  end
                  main_t = clip48(now + SLOT_NS);
                  main_on = 1;
                  return;
               end else begin
                  if (kind_for(cur_dst) == K_BCAST) st = ST_BROADCAST;
                  else if (cur_len < rts_thr) st = ST_DATA;
                  else st = ST_RTS;
                  pend_st = ST_IDLE;
                  peer_a = cur_dst;
               end
            end
            ST_RTS: begin
               transmit(K_RTS, peer_a,
                        SIFS_NS + airtime(CTL_BYTES) + SIFS_NS + airtime(cur_len) + SIFS_NS
                        + airtime(CTL_BYTES),
                        cur_len, airtime(RTS_BYTES),
                        airtime(RTS_BYTES) + SIFS_NS + airtime(CTL_BYTES) + PROP_NS,
                        ST_TIMEOUT, now);
               return;
            end
            ST_TIMEOUT: begin
               retries = retries + 8'd1;
               if (retries >= retry_max) begin
                  emit(A_DROP, kind_for(cur_dst), cur_dst, 0, cur_len);
                  cur_on = 0;
                  st = ST_IDLE;
               end else begin
                  bexp++;
                  if (bexp > BE_MAX) bexp = BE_MAX;
                  bo_ns = ((rnd * ((64'd1 << bexp) - 1) * SLOT_NS) >> 16) + DIFS_NS;
                  bo_susp = 0;
                  st = ST_BACKOFF;
                  pend_st = ST_BACKOFF;
               end
            end
            ST_CTS: begin
               transmit(K_CTS, peer_a,
                        SIFS_NS + airtime(ann_bytes) + SIFS_NS + airtime(CTL_BYTES),
                        CTL_BYTES, airtime(CTL_BYTES),
                        airtime(CTL_BYTES) + SIFS_NS + airtime(ann_bytes) + PROP_NS,
                        ST_CTS_TIMEOUT, now);
               return;
            end
            ST_CTS_TIMEOUT, ST_DONE: begin
               st = pend_st;
               if (st != ST_IDLE) peer_a = cur_dst;
            end
            ST_DATA: begin
               transmit(K_DATA, cur_dst, SIFS_NS + airtime(CTL_BYTES), cur_len,
                        airtime(cur_len),
                        airtime(cur_len) + SIFS_NS + airtime(CTL_BYTES) + PROP_NS,
                        ST_TIMEOUT, now);
               return;
            end
            ST_BROADCAST: begin
               transmit(K_BCAST, cur_dst, 0, cur_len, airtime(cur_len),
                        airtime(cur_len) + SIFS_NS, ST_BROAD_DONE, now);
               return;
            end
            ST_ACK: begin
               transmit(K_ACK, peer_a, 0, CTL_BYTES, airtime(CTL_BYTES),
                        airtime(CTL_BYTES) + SIFS_NS, ST_DONE, now);
               return;
            end
            ST_BROAD_DONE: begin
               emit(A_SENT, K_BCAST, cur_dst, 0, cur_len);
               cur_on = 0;
               st = ST_IDLE;
            end
            default: return;
         endcase
      end
   endfunction

   function automatic void extend_nav(longint unsigned now, longint unsigned dur);
      longint unsigned t;
      t = clip48(now + dur);
      if (nav_t < t) nav_t = t;
   endfunction

   function automatic void arm_sifs(longint unsigned now);
      main_t = clip48(now + SIFS_NS);
      main_on = 1;
   endfunction

   // Works out the result beats of one accepted event into step_res.
   function automatic void mac_predict(event_t ev);
      longint unsigned now, total;
      bit for_us;
      int tail;
      now = ev.now;
      for_us = ev.dst == own_addr;
      step_res.delete();
      case (ev.op)
         OP_TICK: begin
            if (radio_on && now >= radio_t) begin
               radio_on = 0;
               emit(A_RADIO_RX, 0, 0, 0, 0);
            end
            if (main_on && now >= main_t) run_fsm(now, ev.rnd, ev.car, ev.noi);
         end
         OP_SEND: begin
            total = ev.rq_pay + 32;
            if (total > 4095) total = 4095;
            if (q_cnt >= 8) begin
               emit(A_FULL, kind_for(ev.rq_dest), ev.rq_dest, 0, total[11:0]);
            end else begin
               tail = (q_head + q_cnt) % 8;
               q_dest[tail] = ev.rq_dest;
               q_bytes[tail] = total[11:0];
               q_cnt++;
               if (st == ST_IDLE) run_fsm(now, ev.rnd, ev.car, ev.noi);
            end
         end
         OP_RX: begin
            emit(A_RADIO_RX, 0, 0, 0, 0);
            case (ev.kind)
               K_RTS: begin
                  if (!for_us) extend_nav(now, ev.dur);
                  else if (st == ST_IDLE || st == ST_BACKOFF) begin
                     peer_a = ev.src;
                     ann_bytes = ev.rb;
                     pend_st = (st == ST_BACKOFF) ? ST_BACKOFF : ST_IDLE;
                     st = ST_CTS;
                     arm_sifs(now);
                  end
               end
               K_CTS: begin
                  if (!for_us) extend_nav(now, ev.dur);
                  else if (st == ST_TIMEOUT && peer_a == ev.src) begin
                     st = ST_DATA;
                     arm_sifs(now);
                  end
               end
               K_DATA: begin
                  if (!for_us) extend_nav(now, ev.dur);
                  else if ((st == ST_IDLE || st == ST_BACKOFF || st == ST_CTS_TIMEOUT) &&
                           !(st == ST_CTS_TIMEOUT && peer_a != ev.src)) begin
                     pend_st = (st == ST_BACKOFF) ? ST_BACKOFF : ST_IDLE;
                     peer_a = ev.src;
                     st = ST_ACK;
                     arm_sifs(now);
                     emit(A_DELIVER, K_DATA, ev.src, 0, ev.rb);
                  end
               end
               K_BCAST: begin
                  if (ev.dst == BCAST_ADDR) emit(A_DELIVER, K_BCAST, ev.src, 0, ev.rb);
               end
               K_ACK: begin
                  if (for_us && st == ST_TIMEOUT && peer_a == ev.src) begin
                     emit(A_SENT, kind_for(cur_dst), cur_dst, 0, cur_len);
                     cur_on = 0;
                     st = ST_IDLE;
                     run_fsm(now, ev.rnd, ev.car, ev.noi);
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1;
   endfunction

   function automatic longint unsigned next_deadline();
      longint unsigned d;
      d = 64'hFFFF_FFFF_FFFF_FFFF;
      if (radio_on) d = radio_t;
      if (main_on && main_t < d) d = main_t;
      if ((radio_on || main_on) && d > cur_now) return d;
      return cur_now;
   endfunction

   function automatic event_t blank_event(logic [1:0] op);
      event_t ev;
      ev.op = op;
      ev.now = '0;
      ev.car = -8'sd100;
      ev.noi = -8'sd100;
      ev.rnd = $urandom;
      ev.rq_dest = 16'd3;
      ev.rq_pay = '0;
      ev.kind = K_DATA;
      ev.src = 16'd1;
      ev.dst = 16'd2;
      ev.dur = 32'd1000;
      ev.rb = 12'd20;
      return ev;
   endfunction

   function automatic void add_row(event_t ev, bit at_dl, bit typed, logic [2:0] act,
                                   logic [2:0] k, logic [15:0] pa, logic [11:0] b);
      row_t r;
      r.ev = ev;
      r.at_deadline = at_dl;
      r.typed = typed;
      r.want.action = act;
      r.want.frame_kind = k;
      r.want.peer_address = pa;
      r.want.frame_duration_ns = '0;
      r.want.frame_bytes = b;
      rows.push_back(r);
   endfunction

   function automatic event_t random_event();
      event_t ev;
      int r;
      r = $urandom_range(0, 99);
      ev = blank_event(OP_TICK);
      if ($urandom_range(0, 99) < 30) begin
         ev.car = $urandom;
         ev.noi = $urandom;
      end
      ev.rq_dest = ($urandom_range(0, 9) == 0) ? BCAST_ADDR : 16'($urandom);
      ev.rq_pay = ($urandom_range(0, 4) == 0) ? 12'($urandom) : 12'($urandom_range(0, 600));
      ev.kind = ($urandom_range(0, 19) == 0) ? 3'($urandom) : 3'($urandom_range(0, 4));
      ev.src = $urandom;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: ev.dst = own_addr;
         5: ev.dst = BCAST_ADDR;
         default: ev.dst = $urandom;
      endcase
      ev.dur = $urandom_range(0, 1) ? 32'($urandom) : 32'($urandom_range(0, 100000));
      ev.rb = $urandom;
      if (st == ST_TIMEOUT && r < 40) begin
         ev.op = OP_RX;
         ev.kind = $urandom_range(0, 1) ? K_CTS : K_ACK;
         ev.src = peer_a;
         ev.dst = own_addr;
      end else if (st == ST_CTS_TIMEOUT && r < 40) begin
         ev.op = OP_RX;
         ev.kind = K_DATA;
         ev.src = peer_a;
         ev.dst = own_addr;
      end else if (r < 55) begin
         ev.op = OP_TICK;
         cur_now = clip48(next_deadline() + $urandom_range(0, 2000));
      end else if (r < 72) begin
         ev.op = OP_SEND;
      end else if (r < 94) begin
         ev.op = OP_RX;
      end else begin
         ev.op = $urandom_range(0, 1) ? OP_UNUSED : OP_TICK;
      end
      if (ev.op != OP_TICK || r >= 55) cur_now = clip48(cur_now + $urandom_range(0, 5000));
      ev.now = cur_now[47:0];
      return ev;
   endfunction

   task automatic offer(event_t ev, bit typed, res_type want);
      if ($urandom_range(0, 99) < idle_pct) begin
         req.valid = 0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req.op = ev.op;
      req.now_time = ev.now;
      req.carrier_level_dbm = ev.car;
      req.noise_level_dbm = ev.noi;
      req.random_fraction = ev.rnd;
      req.request_dest = ev.rq_dest;
      req.request_payload_bytes = ev.rq_pay;
      req.rx_frame_kind = ev.kind;
      req.rx_source = ev.src;
      req.rx_dest = ev.dst;
      req.rx_duration_ns = ev.dur;
      req.rx_bytes = ev.rb;
      req.valid = 1;
      do @(posedge clock); while (!req.ready);
      mac_predict(ev);
      if (typed && (step_res.size() == 0 || step_res[0].r !== want)) begin
         errors++;
         $display("%0t table row: expected %p, predicted %0d beats", $time, want,
                  step_res.size());
      end
      foreach (step_res[i]) pending_beats.push_back(step_res[i]);
      @(negedge clock);
   endtask

   task automatic random_run(int n);
      repeat (n) offer(random_event(), 0, '0);
   endtask

   task automatic drain();
      req.valid = 0;
      while (pending_beats.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [15:0] data);
      csr_wr_en = 1;
      csr_index = idx;
      csr_wr_data = data;
      @(negedge clock);
      csr_wr_en = 0;
      case (idx)
         CSR_OWN_ADDRESS:   own_addr = data;
         CSR_RTS_THRESHOLD: rts_thr = data[11:0];
         CSR_MAX_RETRIES:   retry_max = data[7:0];
         CSR_BIT_TIME:      bit_ns = data;
         CSR_PHY_HEADER:    phy_hdr = data[7:0];
         CSR_ENERGY_THR:    energy_thr = data[7:0];
         CSR_CS_ENABLE:     cs_en = data[0];
         CSR_NOISE_ENABLE:  noise_en = data[0];
         default: ;
      endcase
   endtask

   task automatic configure(logic [15:0] own, logic [11:0] thr, logic [7:0] rmax,
                            logic [15:0] bt, logic [7:0] phy, logic [7:0] ethr,
                            bit cs, bit ns);
      csr_write(CSR_OWN_ADDRESS, own);
      csr_write(CSR_RTS_THRESHOLD, {4'd0, thr});
      csr_write(CSR_MAX_RETRIES, {8'd0, rmax});
      csr_write(CSR_BIT_TIME, bt);
      csr_write(CSR_PHY_HEADER, {8'd0, phy});
      csr_write(CSR_ENERGY_THR, {8'd0, ethr});
      csr_write(CSR_CS_ENABLE, {15'd0, cs});
      csr_write(CSR_NOISE_ENABLE, {15'd0, ns});
   endtask

   always @(negedge clock) begin
      if (reset) begin
         rsp.ready <= 0;
      end else if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_left <= 400;
         rsp.ready <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp.ready <= 0;
      end else begin
         rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      beat_t e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_beats.size() == 0) begin
            errors++;
            $display("%0t unexpected beat: action %0d kind %0d peer %h dur %0d bytes %0d",
                     $time, rsp.action, rsp.frame_kind, rsp.peer_address,
                     rsp.frame_duration_ns, rsp.frame_bytes);
         end else begin
            e = pending_beats.pop_front();
            if (rsp.action !== e.r.action || rsp.frame_kind !== e.r.frame_kind ||
                rsp.peer_address !== e.r.peer_address ||
                rsp.frame_duration_ns !== e.r.frame_duration_ns ||
                rsp.frame_bytes !== e.r.frame_bytes || rsp.last !== e.last) begin
               errors++;
               $display("%0t mismatch: expected %0d/%0d/%h/%0d/%0d/%0d got %0d/%0d/%h/%0d/%0d/%0d",
                        $time, e.r.action, e.r.frame_kind, e.r.peer_address,
                        e.r.frame_duration_ns, e.r.frame_bytes, e.last, rsp.action,
                        rsp.frame_kind, rsp.peer_address, rsp.frame_duration_ns,
                        rsp.frame_bytes, rsp.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      event_t ev;
      row_t r;
      req.valid = 0;
      req.op = OP_TICK;
      req.now_time = '0;
      req.carrier_level_dbm = '0;
      req.noise_level_dbm = '0;
      req.random_fraction = '0;
      req.request_dest = '0;
      req.request_payload_bytes = '0;
      req.rx_frame_kind = '0;
      req.rx_source = '0;
      req.rx_dest = '0;
      req.rx_duration_ns = '0;
      req.rx_bytes = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed rows, under the reset configuration.
      ev = blank_event(OP_RX);
      ev.kind = K_RTS; ev.dst = 16'd5; ev.rb = 12'd0;
      add_row(ev, 0, 1, A_RADIO_RX, 3'd0, 16'd0, 12'd0);
      ev = blank_event(OP_UNUSED);
      add_row(ev, 0, 0, A_NONE, 3'd0, 16'd0, 12'd0);
      ev = blank_event(OP_RX);
      ev.kind = K_BCAST; ev.src = 16'd9; ev.dst = BCAST_ADDR; ev.rb = 12'hFFF;
      add_row(ev, 0, 1, A_RADIO_RX, 3'd0, 16'd0, 12'd0);
      ev = blank_event(OP_RX);
      ev.kind = K_UNKNOWN;
      add_row(ev, 0, 1, A_RADIO_RX, 3'd0, 16'd0, 12'd0);
      ev = blank_event(OP_SEND);
      ev.rq_dest = BCAST_ADDR; ev.rq_pay = 12'hFFF; ev.car = -8'sd128; ev.noi = -8'sd128;
      add_row(ev, 0, 0, A_NONE, 3'd0, 16'd0, 12'd0);
      ev = blank_event(OP_SEND);
      repeat (8) add_row(ev, 0, 0, A_NONE, 3'd0, 16'd0, 12'd0);
      add_row(ev, 0, 1, A_FULL, K_DATA, 16'd3, 12'd32);
      ev = blank_event(OP_TICK);
      ev.car = 8'sd127;
      add_row(ev, 1, 0, A_NONE, 3'd0, 16'd0, 12'd0);
      ev.car = -8'sd128; ev.noi = 8'sd127;
      add_row(ev, 1, 0, A_NONE, 3'd0, 16'd0, 12'd0);
      ev.noi = -8'sd128;
      repeat (4) add_row(ev, 1, 0, A_NONE, 3'd0, 16'd0, 12'd0);
      ev.rnd = 16'hFFFF;
      add_row(ev, 1, 0, A_NONE, 3'd0, 16'd0, 12'd0);
      ev = blank_event(OP_RX);
      ev.kind = K_DATA; ev.dst = 16'd0; ev.src = 16'hFFFF; ev.dur = 32'hFFFF_FFFF;
      ev.rb = 12'd77;
      add_row(ev, 0, 0, A_NONE, 3'd0, 16'd0, 12'd0);
      ev = blank_event(OP_RX);
      ev.kind = K_CTS; ev.dst = 16'd1; ev.dur = 32'hFFFF_FFFF;
      add_row(ev, 0, 0, A_NONE, 3'd0, 16'd0, 12'd0);

      foreach (rows[i]) begin
         r = rows[i];
         if (r.at_deadline) cur_now = next_deadline();
         else cur_now = clip48(cur_now + 1000);
         r.ev.now = cur_now[47:0];
         offer(r.ev, r.typed, r.want);
      end
      random_run(20);
      drain();

      configure(16'h1234, 12'd0, 8'd1, 16'd1, 8'd255, 8'h80, 1, 0);
      idle_pct = 59;
      random_run(22);
      drain();

      configure(16'hFFFE, 12'hFFF, 8'd255, 16'hFFFF, 8'd0, 8'h7F, 0, 1);
      idle_pct = 0;
      stall_pct = 59;
      random_run(22);
      drain();

      configure(16'd7, 12'd100, 8'd3, 16'd8, 8'd4, 8'hC4, 1, 1);
      idle_pct = 27;
      stall_pct = 27;
      random_run(10);
      // The receiver holds off while items keep coming, so the input stalls.
      idle_pct = 0;
      hold_req++;
      random_run(12);
      drain();
      idle_pct = 27;
      random_run(10);
      drain();

      // Times near the top of the range, so that deadlines and NAV saturate.
      configure(16'd0, 12'd500, 8'd7, 16'd1000, 8'd0, 8'hB6, 1, 1);
      idle_pct = 0;
      stall_pct = 0;
      cur_now = MAX48 - 200000;
      random_run(20);
      drain();

      repeat (100) @(posedge clock);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire

>>> csma_ca_dcf_mac_controller.f
design/cdm_pkg.sv
design/cdm_req_if.sv
design/cdm_rsp_if.sv
design/cdm_ram.sv
design/csma_ca_dcf_mac_controller.sv
sim/tb.sv
